/* rtl/fus_pkg.sv */
// Shared codes, constants and control bundles for the float unary unit.
`default_nettype none
package fus_pkg;

  localparam logic [3:0] ACT_SQRT   = 4'd0;
  localparam logic [3:0] ACT_RSQRT  = 4'd1;
  localparam logic [3:0] ACT_RECIP  = 4'd2;
  localparam logic [3:0] ACT_SQUARE = 4'd3;
  localparam logic [3:0] ACT_ABS    = 4'd4;
  localparam logic [3:0] ACT_NEG    = 4'd5;
  localparam logic [3:0] ACT_ROUND  = 4'd6;
  localparam logic [3:0] ACT_FLOOR  = 4'd7;
  localparam logic [3:0] ACT_CEIL   = 4'd8;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DOMAIN = 2'd1;
  localparam logic [1:0] ST_SKIP   = 2'd2;

  localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
  localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
  localparam logic [31:0] QUIET_BIT = 32'h0040_0000;
  localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;

  typedef struct packed {
    logic load;
    logic check;
    logic link;
    logic norm;
    logic prep;
    logic iter;
    logic round;
    logic emit;
  } fus_cmd_t;

  typedef struct packed {
    logic direct;
    logic chain;
    logic normed;
    logic is_square;
    logic iter_done;
    logic out_busy;
  } fus_sts_t;

endpackage
`default_nettype wire

/* rtl/fus_ctrl.sv */
// Sequencer for the float unary unit.
`default_nettype none
module fus_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  fus_pkg::fus_sts_t sts,
  output fus_pkg::fus_cmd_t cmd
);
  import fus_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CHECK  = 8'b0000_0010,
    S_LINK   = 8'b0000_0100,
    S_NORM   = 8'b0000_1000,
    S_PREP   = 8'b0001_0000,
    S_ITER   = 8'b0010_0000,
    S_ROUND  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (!sts.direct)    state_nxt = S_NORM;
        else if (sts.chain) state_nxt = S_LINK;
        else                state_nxt = S_FINISH;
      end
      S_LINK: begin
        // rsqrt: the rounded root goes back in as a reciprocal request
        cmd.link  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_NORM: begin
        cmd.norm = 1'b1;
        if (sts.normed) state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = sts.is_square ? S_ROUND : S_ITER;
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        if (sts.iter_done) state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = sts.chain ? S_LINK : S_FINISH;
      end
      S_FINISH: begin
        cmd.emit = !sts.out_busy;
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
`default_nettype wire

/* rtl/fus_datapath.sv */
// Datapath: special cases, normalize, shared root/divide recurrence, rounding, output register.
`default_nettype none
module fus_datapath (
  input  wire               clk,
  input  wire               rst_n,
  input  wire  [3:0]        in_action,
  input  wire  [31:0]       in_operand_bits,
  input  wire               in_last_of_run,
  input  fus_pkg::fus_cmd_t cmd,
  output fus_pkg::fus_sts_t sts,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [31:0]       out_value_bits,
  output logic [1:0]        out_status,
  output logic              out_end_of_run
);
  import fus_pkg::*;

  // round half away / floor / ceil on the bit pattern
  function automatic logic [31:0] integral(input logic [31:0] x, input logic [3:0] act);
    logic        sgn;
    logic [31:0] m;
    logic [7:0]  e;
    logic [4:0]  fb;
    logic [31:0] mask;
    logic [31:0] r;
    logic        up;
    sgn  = x[31];
    m    = {1'b0, x[30:0]};
    e    = x[30:23];
    r    = x;
    fb   = 5'd0;
    mask = 32'd0;
    up   = 1'b0;
    if (e >= 8'd150) begin
      r = x;
    end else if (e < 8'd127) begin
      if (act == ACT_ROUND)     r = {sgn, (e == 8'd126) ? ONE_BITS[30:0] : 31'd0};
      else if (m == 32'd0)      r = x;
      else if (act == ACT_FLOOR) r = sgn ? (SIGN_BIT | ONE_BITS) : 32'd0;
      else                      r = sgn ? SIGN_BIT : ONE_BITS;
    end else begin
      fb   = 5'(8'd150 - e);
      mask = (32'd1 << fb) - 32'd1;
      if (act == ACT_ROUND) begin
        m = m + (32'd1 << (fb - 5'd1));
      end else begin
        up = (act == ACT_FLOOR) ? sgn : !sgn;
        if (up && ((m & mask) != 32'd0)) m = (m | mask) + 32'd1;
      end
      r = {sgn, m[30:0] & ~mask[30:0]};
    end
    return r;
  endfunction

  // value = sig * 2^e_in, sig leading one at bit 27 or 26, sticky in bit 0
  function automatic logic [31:0] round_pack(input logic sgn, input logic signed [11:0] e_in,
                                             input logic [27:0] sig_in);
    logic [27:0]        s;
    logic [27:0]        mant_w;
    logic [27:0]        remw;
    logic [27:0]        half;
    logic [27:0]        maskw;
    logic signed [11:0] ee;
    logic signed [11:0] be;
    logic [4:0]         sh;
    logic [31:0]        r;
    logic               rnd;
    s      = sig_in;
    ee     = e_in;
    mant_w = 28'd0;
    remw   = 28'd0;
    half   = 28'd0;
    maskw  = 28'd0;
    sh     = 5'd0;
    rnd    = 1'b0;
    if (!s[27]) begin
      s  = {s[26:0], 1'b0};
      ee = ee - 12'sd1;
    end
    be = ee + 12'sd154;
    if (be >= 12'sd255) begin
      r = {sgn, INF_BITS[30:0]};
    end else if (be >= 12'sd1) begin
      rnd = (s[3:0] > 4'd8) || ((s[3:0] == 4'd8) && s[4]);
      r   = {sgn, 31'd0} | ({1'b0, be[7:0] - 8'd1, 23'd0} + {8'd0, s[27:4]} + {31'd0, rnd});
    end else if (be < -12'sd23) begin
      r = {sgn, 31'd0};
    end else begin
      // subnormal result
      sh     = 5'(12'sd5 - be);
      mant_w = s >> sh;
      maskw  = (28'd1 << sh) - 28'd1;
      remw   = s & maskw;
      half   = 28'd1 << (sh - 5'd1);
      rnd    = (remw > half) || ((remw == half) && mant_w[0]);
      r      = {sgn, 31'd0} | ({4'd0, mant_w} + {31'd0, rnd});
    end
    return r;
  endfunction

  logic [31:0]        x_r;
  logic [3:0]         act_r;
  logic               last_r;
  logic               phase2_r;
  logic [23:0]        m_r;
  logic signed [11:0] ex_r;
  logic signed [11:0] exp_r;
  logic               sign_r;
  logic [27:0]        acc_r;
  logic [29:0]        rem_r;
  logic [55:0]        rad_r;
  logic [4:0]         cnt_r;
  logic [31:0]        res_r;
  logic [1:0]         stat_r;
  logic               run_failed_r;
  logic               out_valid_r;
  logic [31:0]        out_value_r;
  logic [1:0]         out_status_r;
  logic               out_end_r;

  logic [3:0]  eff;
  logic        is_sqrt;
  logic        is_square;
  logic        x_nan;
  logic        x_inf;
  logic        x_zero;
  logic        x_neg;
  logic        chk_direct;
  logic        chk_err;
  logic        chk_skip;
  logic [31:0] chk_val;
  logic [1:0]  chk_stat;
  logic [47:0] prod;
  logic [31:0] sq_p;
  logic [31:0] sq_trial;
  logic        sq_ge;
  logic [29:0] dv_p;
  logic        dv_ge;

  assign eff       = phase2_r ? ACT_RECIP : act_r;
  assign is_sqrt   = (eff == ACT_SQRT) || (eff == ACT_RSQRT);
  assign is_square = (eff == ACT_SQUARE);
  assign x_nan     = x_r[30:0] > INF_BITS[30:0];
  assign x_inf     = x_r[30:0] == INF_BITS[30:0];
  assign x_zero    = x_r[30:0] == 31'd0;
  assign x_neg     = x_r[31] && !x_nan && !x_zero;

  always_comb begin
    chk_direct = 1'b1;
    chk_err    = 1'b0;
    chk_skip   = 1'b0;
    chk_val    = 32'd0;
    if (run_failed_r && !phase2_r) begin
      chk_skip = 1'b1;
    end else begin
      unique case (eff)
        ACT_SQRT, ACT_RSQRT: begin
          if (x_neg)                       chk_err = 1'b1;
          else if (x_nan)                  chk_val = x_r | QUIET_BIT;
          else if (x_zero || x_r == INF_BITS) chk_val = x_r;
          else                             chk_direct = 1'b0;
        end
        ACT_RECIP: begin
          if (x_zero && !phase2_r) chk_err = 1'b1;
          else if (x_nan)          chk_val = x_r | QUIET_BIT;
          else if (x_inf)          chk_val = {x_r[31], 31'd0};
          else if (x_zero)         chk_val = {x_r[31], INF_BITS[30:0]};
          else                     chk_direct = 1'b0;
        end
        ACT_SQUARE: begin
          if (x_nan)       chk_val = x_r | QUIET_BIT;
          else if (x_inf)  chk_val = INF_BITS;
          else if (x_zero) chk_val = 32'd0;
          else             chk_direct = 1'b0;
        end
        ACT_ABS: chk_val = {1'b0, x_r[30:0]};
        ACT_NEG: chk_val = x_r ^ SIGN_BIT;
        ACT_ROUND, ACT_FLOOR, ACT_CEIL:
          chk_val = x_nan ? (x_r | QUIET_BIT) : integral(x_r, eff);
        default: chk_err = 1'b1;
      endcase
    end
    if (chk_skip)     chk_stat = ST_SKIP;
    else if (chk_err) chk_stat = ST_DOMAIN;
    else              chk_stat = ST_OK;
  end

  assign prod     = m_r * m_r;
  assign sq_p     = {rem_r, rad_r[55:54]};
  assign sq_trial = {2'b00, acc_r, 2'b01};
  assign sq_ge    = sq_p >= sq_trial;
  assign dv_p     = {rem_r[28:0], 1'b0};
  assign dv_ge    = dv_p >= {6'd0, m_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r      <= in_operand_bits;
      act_r    <= in_action;
      last_r   <= in_last_of_run;
      phase2_r <= 1'b0;
    end
    if (cmd.link) begin
      x_r      <= res_r;
      phase2_r <= 1'b1;
    end
    if (cmd.check) begin
      res_r  <= chk_val;
      stat_r <= chk_stat;
      m_r    <= {x_r[30:23] != 8'd0, x_r[22:0]};
      ex_r   <= (x_r[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, x_r[30:23]}) - 12'sd150;
      sign_r <= (eff == ACT_RECIP) ? x_r[31] : 1'b0;
    end
    if (cmd.norm && !m_r[23]) begin
      m_r  <= {m_r[22:0], 1'b0};
      ex_r <= ex_r - 12'sd1;
    end
    if (cmd.prep) begin
      cnt_r <= 5'd27;
      if (is_sqrt) begin
        acc_r <= 28'd0;
        rem_r <= 30'd0;
        // make the exponent even; radicand = m << 30, or m << 31 for an odd exponent
        if (ex_r[0]) begin
          rad_r <= {1'b0, m_r, 1'b0, 30'd0};
          exp_r <= (ex_r - 12'sd31) >>> 1;
        end else begin
          rad_r <= {2'b00, m_r, 30'd0};
          exp_r <= (ex_r - 12'sd30) >>> 1;
        end
      end else if (is_square) begin
        acc_r <= prod[47:20];
        rem_r <= {29'd0, |prod[19:0]};
        exp_r <= (ex_r <<< 1) + 12'sd20;
      end else begin
        // quotient bits of 2^50 / m, most significant first
        acc_r <= 28'd0;
        rem_r <= 30'd1 << 22;
        exp_r <= -12'sd50 - ex_r;
      end
    end
    if (cmd.iter) begin
      cnt_r <= cnt_r - 5'd1;
      if (is_sqrt) begin
        rem_r <= sq_ge ? 30'(sq_p - sq_trial) : sq_p[29:0];
        acc_r <= {acc_r[26:0], sq_ge};
        rad_r <= {rad_r[53:0], 2'b00};
      end else begin
        rem_r <= dv_ge ? (dv_p - {6'd0, m_r}) : dv_p;
        acc_r <= {acc_r[26:0], dv_ge};
      end
    end
    if (cmd.round) begin
      res_r  <= round_pack(sign_r, exp_r, {acc_r[27:1], acc_r[0] | (rem_r != 30'd0)});
      stat_r <= ST_OK;
    end
    if (cmd.emit) begin
      out_value_r  <= res_r;
      out_status_r <= stat_r;
      out_end_r    <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      run_failed_r <= 1'b0;
    end else begin
      if (cmd.emit)       out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (cmd.emit) run_failed_r <= last_r ? 1'b0 : (run_failed_r | (stat_r == ST_DOMAIN));
    end
  end

  always_comb begin
    sts.direct    = chk_direct;
    sts.chain     = (act_r == ACT_RSQRT) && !phase2_r && !chk_err && !chk_skip;
    sts.normed    = m_r[23];
    sts.is_square = is_square;
    sts.iter_done = (cnt_r == 5'd0);
    sts.out_busy  = out_valid_r && out_stall;
  end

  assign out_valid      = out_valid_r;
  assign out_value_bits = out_value_r;
  assign out_status     = out_status_r;
  assign out_end_of_run = out_end_r;

endmodule
`default_nettype wire

/* rtl/float_unary_special_unit.sv */
// Top level of the single-precision unary unit.
// One request at a time: sqrt, rsqrt, reciprocal, square, abs, negate, round, floor, ceil on
// an IEEE-754 single word, round-to-nearest-even, subnormals supported. Abs, negate,
// round/floor/ceil and all special operands (NaN, zero, infinity, domain errors, skipped items)
// skip normalization and the recurrence; rsqrt passes a special root through the reciprocal
// check as well. Sqrt and reciprocal normalize a subnormal operand one bit per cycle (up to 23
// bits), then run 28 steps of the shared one-bit-per-cycle root/divide recurrence, then a
// rounding step. Square uses one 24x24 multiply instead of the recurrence. Rsqrt runs the
// root and then the reciprocal back to back. The result sits in an output register, so the
// next request is taken while the previous result waits on out_stall.
`default_nettype none
module float_unary_special_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [3:0]  in_action,
  input  wire  [31:0] in_operand_bits,
  input  wire         in_last_of_run,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] out_value_bits,
  output logic [1:0]  out_status,
  output logic        out_end_of_run
);
  import fus_pkg::*;

  fus_cmd_t cmd;
  fus_sts_t sts;

  fus_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fus_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_action),
    .in_operand_bits (in_operand_bits),
    .in_last_of_run  (in_last_of_run),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value_bits  (out_value_bits),
    .out_status      (out_status),
    .out_end_of_run  (out_end_of_run)
  );

endmodule
`default_nettype wire

/* rtl/fus_checker.sv */
// Port-level checks for the float unary unit, bound to the top level.
`default_nettype none
module fus_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [31:0] out_value_bits,
  input wire [1:0]  out_status,
  input wire        out_end_of_run
);
  import fus_pkg::*;

  // one request in flight: busy right after a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a request was in flight");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_value_bits == 32'd0)
    else $error("nonzero value with failing status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK) || (out_status == ST_DOMAIN) || (out_status == ST_SKIP))
    else $error("bad status code");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value_bits) && $stable(out_status)
      && $stable(out_end_of_run))
    else $error("stalled result changed");

endmodule

bind float_unary_special_unit fus_checker u_fus_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_value_bits (out_value_bits),
  .out_status     (out_status),
  .out_end_of_run (out_end_of_run)
);
`default_nettype wire
